// ----- hw/rtl/mskh_pkg.sv -----
// shared constants, types and arithmetic helpers for the murmur style key hash
package mskh_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned SlotW  = 32;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned RotL   = 31;
  localparam int unsigned ShR    = 33;
  localparam int unsigned NumStages = 10;

  localparam logic [WordW-1:0] MixC1 = 64'h87c37b91114253d5;
  localparam logic [WordW-1:0] MixC2 = 64'h4cf5ad432745937f;
  localparam logic [WordW-1:0] MixC3 = 64'hff51afd7ed558ccd;
  localparam logic [WordW-1:0] MixC4 = 64'hc4ceb9fe1a85ec53;

  localparam logic [CfgIdxW-1:0] CfgSeedIdx = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBaseIdx = 1'd1;

  // partial products of a 64x64 multiply kept mod 2^64
  typedef struct packed {
    logic [WordW-1:0] ll;
    logic [HalfW-1:0] lh;
    logic [HalfW-1:0] hl;
  } mul_pp_t;

  function automatic mul_pp_t mul_pp(input logic [WordW-1:0] x, input logic [WordW-1:0] y);
    mul_pp_t     r;
    logic [WordW-1:0] lh_full;
    logic [WordW-1:0] hl_full;
    r.ll    = WordW'(x[HalfW-1:0]) * WordW'(y[HalfW-1:0]);
    lh_full = WordW'(x[HalfW-1:0]) * WordW'(y[WordW-1:HalfW]);
    hl_full = WordW'(x[WordW-1:HalfW]) * WordW'(y[HalfW-1:0]);
    r.lh    = lh_full[HalfW-1:0];
    r.hl    = hl_full[HalfW-1:0];
    return r;
  endfunction

  function automatic logic [WordW-1:0] mul_sum(input mul_pp_t p);
    logic [HalfW-1:0] mid_sum;
    mid_sum = p.lh + p.hl;
    return p.ll + {mid_sum, HalfW'(0)};
  endfunction

  function automatic logic [WordW-1:0] xor_shr(input logic [WordW-1:0] x);
    return x ^ (x >> ShR);
  endfunction

  function automatic logic [WordW-1:0] rot_left(input logic [WordW-1:0] x);
    return (x << RotL) | (x >> (WordW - RotL));
  endfunction

endpackage

// ----- hw/rtl/murmur_style_key_hash.sv -----
// top level of the murmur style key hash: ten stage pipeline, one key per cycle
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  input    | start, busy      | key_i[63:0], slot_i[31:0]
//  result   | done_o (strobe)  | hash_value_o[63:0], result_slot_o[31:0]
//  config   | cfg_we_i         | cfg_idx_i[0], cfg_wdata_i[63:0]
//
// a word is taken every cycle; busy stays low
// depth is mostly four chained 64-bit multiply steps, each split into
// a 32-bit partial product stage and a combine stage
// reset clears the stage valid bits and the config registers
// results are strobed once and cannot be stalled, so the pipeline never holds
module murmur_style_key_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mskh_pkg::WordW-1:0]    key_i,
  input  logic [mskh_pkg::SlotW-1:0]    slot_i,
  input  logic                          cfg_we_i,
  input  logic [mskh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mskh_pkg::WordW-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [mskh_pkg::WordW-1:0]    hash_value_o,
  output logic [mskh_pkg::SlotW-1:0]    result_slot_o
);

  localparam int unsigned NS = mskh_pkg::NumStages;
  localparam int unsigned W  = mskh_pkg::WordW;

  logic [mskh_pkg::SeedW-1:0] seed_q;
  logic [W-1:0]               base_q;

  logic [NS-1:0]              valid_q;
  logic [mskh_pkg::SlotW-1:0] slot_q [NS];

  mskh_pkg::mul_pp_t pp1_q, pp3_q, ppa6_q, ppb6_q, ppa8_q, ppb8_q;
  logic [W-1:0] h2_q, a4_q, a5_q, b5_q, a7_q, b7_q, a9_q, b9_q, hash_q;

  logic [W-1:0] seed64;
  logic [W-1:0] a5_d, b5_d, sum_ab, sum_a2b;

  assign busy   = 1'b0;
  assign seed64 = {seed_q, seed_q};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mskh_pkg::CfgSeedIdx: seed_q <= cfg_wdata_i[mskh_pkg::SeedW-1:0];
        mskh_pkg::CfgBaseIdx: base_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // valid bits travel with the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_i;
    for (int i = 1; i < NS; i++) begin
      slot_q[i] <= slot_q[i-1];
    end
  end

  always_comb begin
    a5_d    = a4_q + base_q;
    b5_d    = a4_q + (base_q << 1);
    a5_d    = mskh_pkg::xor_shr(mskh_pkg::xor_shr(a5_d));
    b5_d    = mskh_pkg::xor_shr(mskh_pkg::xor_shr(b5_d));
    sum_ab  = a9_q + b9_q;
    sum_a2b = a9_q + (b9_q << 1);
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pp1_q  <= mskh_pkg::mul_pp(key_i, mskh_pkg::MixC1);
    h2_q   <= mskh_pkg::rot_left(mskh_pkg::mul_sum(pp1_q));
    pp3_q  <= mskh_pkg::mul_pp(h2_q, mskh_pkg::MixC2);
    a4_q   <= mskh_pkg::mul_sum(pp3_q) ^ seed64;
    a5_q   <= a5_d;
    b5_q   <= b5_d;
    ppa6_q <= mskh_pkg::mul_pp(a5_q, mskh_pkg::MixC3);
    ppb6_q <= mskh_pkg::mul_pp(b5_q, mskh_pkg::MixC3);
    a7_q   <= mskh_pkg::xor_shr(mskh_pkg::mul_sum(ppa6_q));
    b7_q   <= mskh_pkg::xor_shr(mskh_pkg::mul_sum(ppb6_q));
    ppa8_q <= mskh_pkg::mul_pp(a7_q, mskh_pkg::MixC4);
    ppb8_q <= mskh_pkg::mul_pp(b7_q, mskh_pkg::MixC4);
    a9_q   <= mskh_pkg::xor_shr(mskh_pkg::mul_sum(ppa8_q));
    b9_q   <= mskh_pkg::xor_shr(mskh_pkg::mul_sum(ppb8_q));
    hash_q <= sum_ab ^ sum_a2b;
  end

  assign done_o        = valid_q[NS-1];
  assign hash_value_o  = hash_q;
  assign result_slot_o = slot_q[NS-1];

  // a result strobe follows an accepted word by the pipeline depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start & ~busy, NS))
    else $error("result strobe without matching accepted word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start & ~busy, NS) && $past(rst_ni, NS) |-> done_o)
    else $error("accepted word lost in pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_slot_o == $past(slot_i, NS))
    else $error("result slot does not match accepted slot");

endmodule
